/* sv/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* sv/dq_pkg.sv */
// types, request and status codes for the double-ended queue
`timescale 1ns / 1ps
package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_WIDTH = 32;
   localparam int FILL_WIDTH = 5;

   typedef logic [1:0] req_code_type;
   typedef logic [1:0] status_type;
   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic [FILL_WIDTH-1:0] fill_type;

   localparam req_code_type REQ_PUSH_FRONT = 2'd0;
   localparam req_code_type REQ_PUSH_BACK = 2'd1;
   localparam req_code_type REQ_POP_FRONT = 2'd2;
   localparam req_code_type REQ_POP_BACK = 2'd3;

   localparam status_type ST_DONE = 2'd0;
   localparam status_type ST_EMPTY_POP = 2'd1;
   localparam status_type ST_FULL_PUSH = 2'd2;

endpackage

/* sv/dq_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/double_ended_queue.sv */
// double-ended queue top level: ring pointers, end-value cache and ring store
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_type, req_value
//   rsp       out        rsp_valid/rsp_stall  rsp_status, rsp_front_value, rsp_back_value,
//                                             rsp_is_empty, rsp_is_full, rsp_fill_count
//
// pushes, ignored requests and pops that empty the deque respond in the next cycle, with no ring read
// a pop that leaves values first waits on the ring store's registered read of the new end
// one result word is held in the output registers; req_stall is high while it is stalled or during a fill
// synchronous reset empties the deque at once, the ring store itself is not cleared
`timescale 1ns / 1ps
module double_ended_queue #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dq_pkg::req_code_type  req_type,
   input  dq_pkg::word_type      req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dq_pkg::status_type    rsp_status,
   output dq_pkg::word_type      rsp_front_value,
   output dq_pkg::word_type      rsp_back_value,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   output dq_pkg::fill_type      rsp_fill_count
);
   import dq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FILL_FRONT = 2'd1;
   localparam logic [1:0] S_FILL_BACK = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] front_idx_ff, front_idx_in;
   logic [CW-1:0] count_ff, count_in;
   status_type    status_ff, status_in;
   word_type      front_ff, front_in;
   word_type      back_ff, back_in;

   logic          accept;
   logic          empty_now, full_now, last_one;
   logic [AW-1:0] idx_prev, idx_next, idx_tail, idx_last2;
   logic [SW-1:0] sum_tail, sum_last2;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [WORD_WIDTH-1:0] wr_data, rd_data;
   logic [CW+FILL_WIDTH-1:0] count_ext;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;

   assign empty_now = (count_ff == '0);
   assign full_now = (count_ff == CW'(DEPTH));
   assign last_one = (count_ff == CW'(1));

   // ring neighbors of the front and the two back positions
   assign idx_prev = (front_idx_ff == '0) ? AW'(DEPTH - 1) : front_idx_ff - AW'(1);
   assign idx_next = (front_idx_ff == AW'(DEPTH - 1)) ? '0 : front_idx_ff + AW'(1);
   assign sum_tail = {1'b0, front_idx_ff} + SW'(count_ff);
   assign sum_last2 = {1'b0, front_idx_ff} + SW'(count_ff) - SW'(2);
   assign idx_tail = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
   assign idx_last2 = (sum_last2 >= SW'(DEPTH)) ? AW'(sum_last2 - SW'(DEPTH))
                                                 : AW'(sum_last2);

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      front_idx_in = front_idx_ff;
      count_in = count_ff;
      status_in = status_ff;
      front_in = front_ff;
      back_in = back_ff;
      wr_en = 1'b0;
      wr_addr = idx_tail;
      wr_data = req_value;
      rd_en = 1'b0;
      rd_addr = idx_next;

      unique case (state_ff)
         S_FILL_FRONT: begin
            front_in = rd_data;
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_FILL_BACK: begin
            back_in = rd_data;
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            if (accept) begin
               status_in = ST_DONE;
               unique case (req_type)
                  REQ_PUSH_FRONT: begin
                     if (full_now) begin
                        status_in = ST_FULL_PUSH;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = idx_prev;
                        front_idx_in = idx_prev;
                        count_in = count_ff + CW'(1);
                        front_in = req_value;
                        if (empty_now) begin
                           back_in = req_value;
                        end
                     end
                  end
                  REQ_PUSH_BACK: begin
                     if (full_now) begin
                        status_in = ST_FULL_PUSH;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = idx_tail;
                        count_in = count_ff + CW'(1);
                        back_in = req_value;
                        if (empty_now) begin
                           front_in = req_value;
                        end
                     end
                  end
                  REQ_POP_FRONT: begin
                     if (empty_now) begin
                        status_in = ST_EMPTY_POP;
                     end else begin
                        front_idx_in = idx_next;
                        count_in = count_ff - CW'(1);
                        if (last_one) begin
                           front_in = '0;
                           back_in = '0;
                        end else begin
                           rd_en = 1'b1;
                           rd_addr = idx_next;
                           state_in = S_FILL_FRONT;
                        end
                     end
                  end
                  REQ_POP_BACK: begin
                     if (empty_now) begin
                        status_in = ST_EMPTY_POP;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (last_one) begin
                           front_in = '0;
                           back_in = '0;
                        end else begin
                           rd_en = 1'b1;
                           rd_addr = idx_last2;
                           state_in = S_FILL_BACK;
                        end
                     end
                  end
               endcase
               // the result waits for the ring read when a new end must be fetched
               rsp_valid_in = (state_in == S_IDLE);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         front_idx_ff <= '0;
         count_ff <= '0;
         status_ff <= ST_DONE;
         front_ff <= '0;
         back_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         front_idx_ff <= front_idx_in;
         count_ff <= count_in;
         status_ff <= status_in;
         front_ff <= front_in;
         back_ff <= back_in;
      end
   end

   dq_ram #(
      .WIDTH(WORD_WIDTH),
      .DEPTH(DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // the end cache and count only move on an accepted word or its ring read, so they double as the result
   assign count_ext = {{FILL_WIDTH{1'b0}}, count_ff};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_front_value = front_ff;
   assign rsp_back_value = back_ff;
   assign rsp_is_empty = empty_now;
   assign rsp_is_full = full_now;
   assign rsp_fill_count = count_ext[FILL_WIDTH-1:0];

endmodule

/* sv/dq_checker.sv */
// port-level checker for the double-ended queue, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dq_checker #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input dq_pkg::status_type   rsp_status,
   input dq_pkg::word_type     rsp_front_value,
   input dq_pkg::word_type     rsp_back_value,
   input logic                 rsp_is_empty,
   input logic                 rsp_is_full,
   input dq_pkg::fill_type     rsp_fill_count
);
   import dq_pkg::*;

   localparam fill_type FULL_COUNT = FILL_WIDTH'(DEPTH);
   localparam int RSP_BITS = $bits(status_type) + 2 * WORD_WIDTH + 2 + FILL_WIDTH;

   logic                empty_clean;
   logic                full_clean;
   logic [RSP_BITS-1:0] rsp_word;

   assign empty_clean = (rsp_fill_count == '0) && (rsp_front_value == '0) &&
                        (rsp_back_value == '0);
   assign full_clean = (rsp_fill_count == FULL_COUNT) && !rsp_is_empty;
   assign rsp_word = {rsp_status, rsp_front_value, rsp_back_value, rsp_is_empty, rsp_is_full,
                      rsp_fill_count};

   // an empty deque reports no count and zero end values
   `ASSERT_IMPLY(a_empty_word, clock, reset, rsp_valid && rsp_is_empty, empty_clean)

   `ASSERT_IMPLY(a_full_count, clock, reset, rsp_valid && rsp_is_full, full_clean)

   // an ignored request leaves the deque at the bound that caused it
   `ASSERT_IMPLY(a_pop_ignored, clock, reset, rsp_valid && (rsp_status == ST_EMPTY_POP), rsp_is_empty)

   `ASSERT_IMPLY(a_push_dropped, clock, reset, rsp_valid && (rsp_status == ST_FULL_PUSH), rsp_is_full)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
